[design/dlts_pkg.sv]
package dlts_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int TICK_W   = 32;
  localparam int OFFSET_W = 24;

  // event kinds on in_tuser
  localparam logic FUNC_DELAY = 1'b0;
  localparam logic FUNC_WAIT  = 1'b1;

  // sequencer modes
  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_COLLECT = 2'd1;
  localparam logic [1:0] MODE_REPLAY  = 2'd2;

  typedef struct packed {
    logic [OFFSET_W-1:0] jump_target;
    logic                jump;
    logic [TICK_W-1:0]   ticks_out;
  } result_t;

endpackage

[design/dlts_ram.sv]
module dlts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/dlts_ctrl.sv]
module dlts_ctrl #(
  parameter int MAX_ENTRIES = dlts_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_i,
  input  logic                          func_i,
  input  logic [dlts_pkg::TICK_W-1:0]   ticks_i,
  input  logic [dlts_pkg::OFFSET_W-1:0] offset_i,
  output dlts_pkg::result_t             res_o
);
  import dlts_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam logic [CW-1:0] LAST_DELAY = CW'(MAX_ENTRIES - 1);
  localparam logic [CW-1:0] FULL       = CW'(MAX_ENTRIES);

  logic [1:0]          mode_r, mode_nxt;
  logic [OFFSET_W-1:0] start_r, start_nxt;
  logic [TICK_W-1:0]   remain_r, remain_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       rindex_r, rindex_nxt;

  logic                wr_en;
  logic [TICK_W-1:0]   ram_rdata;
  logic                byp_valid_r;
  logic [TICK_W-1:0]   byp_data_r;
  logic [TICK_W-1:0]   entry;
  logic                pop_ok;
  logic [TICK_W-1:0]   popped;

  // the entry at rindex_r is fetched ahead through rindex_nxt; a write to the
  // same slot while it is being read is forwarded
  assign entry  = byp_valid_r ? byp_data_r : ram_rdata;
  assign pop_ok = rindex_r < count_r;
  assign popped = (entry > remain_r) ? remain_r : entry;

  always_comb begin
    mode_nxt   = mode_r;
    start_nxt  = start_r;
    remain_nxt = remain_r;
    count_nxt  = count_r;
    rindex_nxt = rindex_r;
    wr_en      = 1'b0;
    res_o      = '0;
    if (step_i) begin
      if (func_i == FUNC_DELAY) begin
        if (mode_r == MODE_REPLAY) begin
          if (pop_ok) begin
            res_o.ticks_out = popped;
            remain_nxt      = remain_r - popped;
            rindex_nxt      = rindex_r + CW'(1);
          end
        end else if (ticks_i != '0 && count_r < LAST_DELAY) begin
          if (count_r == '0) begin
            mode_nxt  = MODE_COLLECT;
            start_nxt = offset_i;
          end
          remain_nxt = remain_r + ticks_i;
          wr_en      = 1'b1;
          count_nxt  = count_r + CW'(1);
        end
      end else if (count_r == '0) begin
        res_o.ticks_out = ticks_i;
      end else if (mode_r == MODE_REPLAY) begin
        if (pop_ok) begin
          res_o.ticks_out = popped;
          remain_nxt      = remain_r - popped;
        end
        mode_nxt   = MODE_NONE;
        rindex_nxt = '0;
        count_nxt  = '0;
      end else if (ticks_i == '0 || count_r >= FULL) begin
        rindex_nxt = '0;
        count_nxt  = '0;
      end else begin
        remain_nxt        = ticks_i;
        mode_nxt          = MODE_REPLAY;
        wr_en             = 1'b1;
        count_nxt         = count_r + CW'(1);
        res_o.jump        = 1'b1;
        res_o.jump_target = start_r;
      end
    end
  end

  dlts_ram #(
    .WIDTH (TICK_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata (ticks_i),
    .raddr (rindex_nxt[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NONE;
      start_r     <= '0;
      remain_r    <= '0;
      count_r     <= '0;
      rindex_r    <= '0;
      byp_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      start_r     <= start_nxt;
      remain_r    <= remain_nxt;
      count_r     <= count_nxt;
      rindex_r    <= rindex_nxt;
      byp_valid_r <= wr_en && (count_r[AW-1:0] == rindex_nxt[AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= ticks_i;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("entry count beyond list size");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rindex_r <= count_r)
    else $error("replay index past entry count");

  a_index_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_REPLAY |-> rindex_r == '0)
    else $error("replay index moved outside replay");

  a_jump_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    res_o.jump |-> (res_o.ticks_out == '0 && mode_nxt == MODE_REPLAY))
    else $error("jump issued with ticks or without entering replay");

  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !res_o.jump |-> res_o.jump_target == '0)
    else $error("jump target set without jump");

endmodule

[design/delay_list_tick_scheduler.sv]
// Delay-list tick scheduler: one timing event per transaction on the in_
// stream (in_tuser 0 = delay, 1 = wait) gives exactly one result on the out_
// stream, registered and shown in the cycle after acceptance. A new event can be taken in
// every cycle; in_tready is low only while a result is held and out_tready is
// low. All work happens in a single pass from the state registers to the
// result register; the entry list sits in a RAM with registered read and the
// next entry to replay is fetched ahead of use, so no clearing pass is needed
// after reset. MAX_ENTRIES sets the list length, one slot being kept for the
// closing wait.
module delay_list_tick_scheduler #(
  parameter int MAX_ENTRIES = dlts_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [31:0] tick_count, [55:32] instr_offset
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [31:0] ticks_out, [32] jump, [56:33] jump_target
);
  import dlts_pkg::*;

  logic    step;
  result_t res;
  result_t out_data_r;
  logic    out_valid_r, out_valid_nxt;

  assign in_tready     = !out_valid_r || out_tready;
  assign step          = in_tvalid && in_tready;
  assign out_valid_nxt = step || (out_valid_r && !out_tready);

  dlts_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .func_i   (in_tuser),
    .ticks_i  (in_tdata[31:0]),
    .offset_i (in_tdata[55:32]),
    .res_o    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_data_r.jump_target, out_data_r.jump,
                       out_data_r.ticks_out};

endmodule
